@@ hdl/msp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and codes for the multi-stack shared pool.
// ----------------------------------------------------------------------------
package msp_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_WR,
      ST_POP_TOP,
      ST_POP_DATA
   } state_type;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BAD_ID = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   // Requests from the sequencer to the free list.
   typedef struct packed {
      logic rd;     // read the slot at the head of the list
      logic take;   // consume the head slot
      logic give;   // append a released slot at the tail
   } free_req_type;

   typedef struct packed {
      logic empty;
      logic full;
   } free_stat_type;

endpackage

@@ hdl/msp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module msp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // The read register holds its value until the next read.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/msp_free_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_free_list
// FIFO of free pool slots, kept in RAM, starting out as 0 to depth-1.
// ----------------------------------------------------------------------------
module msp_free_list #(
   parameter int POOL_DEPTH = 64,
   localparam int SW = $clog2(POOL_DEPTH),
   localparam int CW = $clog2(POOL_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  msp_pkg::free_req_type req,
   input  logic [SW-1:0]         give_slot,
   output logic [SW-1:0]         head_slot,
   output msp_pkg::free_stat_type stat
);
   import msp_pkg::*;

   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   // Number of list positions written so far; positions at or above it still
   // hold their initial contents, which equal their own index.
   logic [CW-1:0] fill_ff, fill_in;
   logic          take_ok;
   logic          give_ok;
   logic [SW-1:0] rd_data;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(POOL_DEPTH));

   assign take_ok = req.take && !stat.empty;
   assign give_ok = req.give && !stat.full;

   msp_ram #(
      .WIDTH (SW),
      .DEPTH (POOL_DEPTH)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (give_ok),
      .wr_addr (tail_ff),
      .wr_data (give_slot),
      .rd_en   (req.rd),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign head_slot = (CW'(head_ff) < fill_ff) ? rd_data : head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      if (take_ok) begin
         head_in  = (head_ff == SW'(POOL_DEPTH - 1)) ? '0 : head_ff + SW'(1);
         count_in = count_ff - CW'(1);
      end
      if (give_ok) begin
         tail_in  = (tail_ff == SW'(POOL_DEPTH - 1)) ? '0 : tail_ff + SW'(1);
         count_in = count_ff + CW'(1);
         if (fill_ff != CW'(POOL_DEPTH)) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= CW'(POOL_DEPTH);
         fill_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   a_no_take_and_give: assert property (@(posedge clock) disable iff (reset)
      !(req.take && req.give))
      else $error("free list asked to take and give in one cycle");

   a_take_when_empty: assert property (@(posedge clock) disable iff (reset)
      req.take |-> !stat.empty)
      else $error("slot taken from an empty free list");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!req.take && !req.give) |=> $stable(count_ff))
      else $error("free count moved without a request");

endmodule

@@ hdl/multi_stack_shared_pool_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_top
// Several LIFO stacks sharing one slot pool with a FIFO free list.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low. It
//   carries req_command (push or pop), req_stack_id (one-based) and
//   req_value. Every request gives exactly one response, shown for one cycle
//   with rsp_valid high: rsp_status and, for a successful pop,
//   rsp_popped_value. The receiver cannot stall; each response must be taken
//   in the cycle it is shown, and a new request may be taken in that cycle.
//   States passed from the accepting edge to the response (busy high in them):
//     bad stack number or pool full : registered with no state, busy stays low
//     push                          : ST_PUSH_WR
//     pop from an empty stack       : ST_POP_TOP
//     pop                           : ST_POP_TOP, then ST_POP_DATA
//   A pop makes two dependent reads of synchronous RAM: the
//   stack top pointer, then the linked entry at that slot.
//   csr_we writes csr_wdata to the stacks-in-use register (reset 3).
//   Reset empties every stack and refills the free list at once; there is
//   no clearing pass.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_top #(
   parameter int POOL_DEPTH = 64,
   parameter int MAX_STACKS = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [3:0]         req_stack_id,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_popped_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [3:0]         csr_wdata
);
   import msp_pkg::*;

   localparam int SW  = $clog2(POOL_DEPTH);
   localparam int PW  = $clog2(POOL_DEPTH + 1);
   localparam int SIW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int EW  = DATA_WIDTH + PW;
   localparam logic [PW-1:0] NO_SLOT = PW'(POOL_DEPTH);

   state_type state_ff, state_in;

   logic [3:0]            stacks_in_use_ff;
   logic                  cmd_ff, cmd_in;
   logic [SIW-1:0]        sidx_ff, sidx_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [PW-1:0]         top_ff, top_in;
   logic [MAX_STACKS-1:0] top_valid_ff, top_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_popped_ff, rsp_popped_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic [7:0]            id8;
   logic [7:0]            id_m1;
   logic [7:0]            limit8;
   logic                  bad_id;
   logic [DATA_WIDTH-1:0] req_data;
   logic [31:0]           pop_ext;

   logic                  top_wr_en;
   logic [SIW-1:0]        top_wr_addr;
   logic [PW-1:0]         top_wr_data;
   logic                  top_rd_en;
   logic [PW-1:0]         top_rd_data;
   logic [PW-1:0]         top_cur;

   logic                  ent_wr_en;
   logic [SW-1:0]         ent_wr_addr;
   logic [EW-1:0]         ent_wr_data;
   logic                  ent_rd_en;
   logic [SW-1:0]         ent_rd_addr;
   logic [EW-1:0]         ent_rd_data;

   free_req_type          fl_req;
   free_stat_type         fl_stat;
   logic [SW-1:0]         head_slot;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Stack number check, done at full width so any stack count fits.
   assign id8    = 8'(req_stack_id);
   assign id_m1  = id8 - 8'd1;
   assign limit8 = (8'(stacks_in_use_ff) > 8'(MAX_STACKS)) ? 8'(MAX_STACKS)
                                                           : 8'(stacks_in_use_ff);
   assign bad_id = (id8 == 8'd0) || (id8 > limit8);

   generate
      if (DATA_WIDTH > 32) begin : g_wide
         assign req_data = {{(DATA_WIDTH - 32){1'b0}}, req_value};
         assign pop_ext  = ent_rd_data[31:0];
      end else if (DATA_WIDTH == 32) begin : g_equal
         assign req_data = req_value;
         assign pop_ext  = ent_rd_data[31:0];
      end else begin : g_narrow
         assign req_data = req_value[DATA_WIDTH-1:0];
         assign pop_ext  = {{(32 - DATA_WIDTH){ent_rd_data[DATA_WIDTH-1]}},
                            ent_rd_data[DATA_WIDTH-1:0]};
      end
   endgenerate

   // A stack whose top was never written is empty.
   assign top_cur = top_valid_ff[sidx_ff] ? top_rd_data : NO_SLOT;

   msp_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_STACKS)
   ) u_top_ram (
      .clock   (clock),
      .wr_en   (top_wr_en),
      .wr_addr (top_wr_addr),
      .wr_data (top_wr_data),
      .rd_en   (top_rd_en),
      .rd_addr (id_m1[SIW-1:0]),
      .rd_data (top_rd_data)
   );

   // Each entry holds the slot below it and the pushed value.
   msp_ram #(
      .WIDTH (EW),
      .DEPTH (POOL_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   msp_free_list #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_free_list (
      .clock     (clock),
      .reset     (reset),
      .req       (fl_req),
      .give_slot (top_ff[SW-1:0]),
      .head_slot (head_slot),
      .stat      (fl_stat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !bad_id) begin
               if (req_command == CMD_POP) begin
                  state_in = ST_POP_TOP;
               end else if (!fl_stat.empty) begin
                  state_in = ST_PUSH_WR;
               end
            end
         end
         ST_PUSH_WR: begin
            state_in = ST_IDLE;
         end
         ST_POP_TOP: begin
            state_in = (top_cur == NO_SLOT) ? ST_IDLE : ST_POP_DATA;
         end
         ST_POP_DATA: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      sidx_in       = sidx_ff;
      value_in      = value_ff;
      top_in        = top_ff;
      top_valid_in  = top_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_popped_in = '0;
      rsp_status_in = STATUS_OK;
      top_rd_en     = 1'b0;
      top_wr_en     = 1'b0;
      top_wr_addr   = sidx_ff;
      top_wr_data   = NO_SLOT;
      ent_wr_en     = 1'b0;
      ent_wr_addr   = head_slot;
      ent_wr_data   = {top_cur, value_ff};
      ent_rd_en     = 1'b0;
      ent_rd_addr   = top_cur[SW-1:0];
      fl_req        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               sidx_in  = id_m1[SIW-1:0];
               value_in = req_data;
               if (bad_id) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_BAD_ID;
               end else if (req_command == CMD_PUSH && fl_stat.empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  top_rd_en = 1'b1;
                  fl_req.rd = (req_command == CMD_PUSH);
               end
            end
         end
         ST_PUSH_WR: begin
            ent_wr_en             = 1'b1;
            top_wr_en             = 1'b1;
            top_wr_data           = PW'(head_slot);
            top_valid_in[sidx_ff] = 1'b1;
            fl_req.take           = 1'b1;
            rsp_valid_in          = 1'b1;
            rsp_status_in         = STATUS_OK;
         end
         ST_POP_TOP: begin
            top_in = top_cur;
            if (top_cur == NO_SLOT) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EMPTY;
            end else begin
               ent_rd_en = 1'b1;
            end
         end
         ST_POP_DATA: begin
            top_wr_en     = 1'b1;
            top_wr_data   = ent_rd_data[EW-1:DATA_WIDTH];
            fl_req.give   = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_popped_in = pop_ext;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         stacks_in_use_ff <= 4'd3;
         top_valid_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_valid_ff <= top_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            stacks_in_use_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sidx_ff       <= sidx_in;
      value_ff      <= value_in;
      top_ff        <= top_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;

   a_push_completes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH_WR |=> rsp_valid && rsp_status == STATUS_OK)
      else $error("push finished without an ok response");

   a_pop_completes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP_DATA |=> rsp_valid && rsp_status == STATUS_OK)
      else $error("pop finished without an ok response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_popped_value == '0)
      else $error("failed request returned a nonzero value");

   a_push_is_push: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH_WR |-> cmd_ff == CMD_PUSH && !fl_stat.empty)
      else $error("push write stage without a free slot");

   a_pop_slot_used: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP_DATA |-> !fl_stat.full && top_ff != NO_SLOT)
      else $error("pop of a slot that is not allocated");

endmodule
